[sv/motor_rewind_homing_controller_defines.svh]
// Assertion macros used by the rewind homing controller RTL.
`ifndef MOTOR_REWIND_HOMING_CONTROLLER_DEFINES_SVH
`define MOTOR_REWIND_HOMING_CONTROLLER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define MRHC_ASSERT_NOW(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies a consequence in the following cycle.
`define MRHC_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("assertion failed: next-cycle implication");

`endif

[sv/mrhc_pkg.sv]
// Types and constants for the rewind homing controller.
package mrhc_pkg;

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_START  = 2'd2,
    FUNC_ABORT  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STARTED  = 3'd1,
    EV_SKIPPED  = 3'd2,
    EV_COMPLETE = 3'd3,
    EV_TIMEOUT  = 3'd4,
    EV_SWITCHED = 3'd5,
    EV_ABORTED  = 3'd6
  } event_t;

  localparam int CFG_WIDTH     = 16;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int ELAPSED_WIDTH = 17;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_HOME    = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MARGIN  = 2'd2;

  localparam logic [CFG_WIDTH-1:0] HOME_RESET    = 16'd25;
  localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = 16'd15000;
  localparam logic [CFG_WIDTH-1:0] MARGIN_RESET  = 16'd200;

  localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = 17'd131071;

  typedef struct packed {
    logic   drive_a;
    logic   drive_b;
    logic   brake_release;
    logic   rewinding;
    event_t event_res;
  } result_t;

endpackage

[sv/mrhc_core.sv]
// Rewind state, configuration registers and per-request decision logic.
module mrhc_core #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [mrhc_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [mrhc_pkg::CFG_WIDTH-1:0]        cfg_data,
  input  logic                                  fire,
  input  mrhc_pkg::func_t                       func,
  input  logic signed [POSITION_WIDTH-1:0]      position,
  output mrhc_pkg::result_t                     result
);
  import mrhc_pkg::*;

  localparam int CW = POSITION_WIDTH + 1;

  logic [CFG_WIDTH-1:0] home_position;
  logic [CFG_WIDTH-1:0] timeout_ms;
  logic [CFG_WIDTH-1:0] wrong_way_margin;

  logic                             active, active_next;
  logic                             reversing, reversing_next;
  logic                             switched, switched_next;
  logic signed [POSITION_WIDTH-1:0] start_position, start_position_next;
  logic [ELAPSED_WIDTH-1:0]         elapsed_ms, elapsed_ms_next;

  logic signed [CW-1:0] pos_ext;
  logic signed [CW-1:0] start_ext;
  logic signed [CW-1:0] home_ext;
  logic signed [CW-1:0] margin_ext;
  logic signed [CW-1:0] diff;
  logic                 at_home;
  logic                 timed_out;
  logic                 wrong_way;
  logic                 brake;
  event_t               ev;

  // Widen by one bit so the compares and the difference cannot overflow.
  assign pos_ext    = {position[POSITION_WIDTH-1], position};
  assign start_ext  = {start_position[POSITION_WIDTH-1], start_position};
  assign home_ext   = {{(CW-CFG_WIDTH){1'b0}}, home_position};
  assign margin_ext = {{(CW-CFG_WIDTH){1'b0}}, wrong_way_margin};
  assign diff       = pos_ext - start_ext;

  assign at_home   = (pos_ext <= home_ext);
  assign timed_out = (elapsed_ms > {1'b0, timeout_ms});
  assign wrong_way = (diff > margin_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      home_position    <= HOME_RESET;
      timeout_ms       <= TIMEOUT_RESET;
      wrong_way_margin <= MARGIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOME:    home_position    <= cfg_data;
        CFG_TIMEOUT: timeout_ms       <= cfg_data;
        CFG_MARGIN:  wrong_way_margin <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    active_next         = active;
    reversing_next      = reversing;
    switched_next       = switched;
    start_position_next = start_position;
    elapsed_ms_next     = elapsed_ms;
    brake               = 1'b0;
    ev                  = EV_NONE;
    unique case (func)
      FUNC_UPDATE: begin
        if (active) begin
          priority if (at_home) begin
            active_next = 1'b0;
            brake       = 1'b1;
            ev          = EV_COMPLETE;
          end else if (timed_out) begin
            active_next = 1'b0;
            brake       = 1'b1;
            ev          = EV_TIMEOUT;
          end else if (!switched && wrong_way) begin
            switched_next  = 1'b1;
            reversing_next = 1'b0;
            ev             = EV_SWITCHED;
          end else begin
            ev = EV_NONE;
          end
        end
      end
      FUNC_TICK: begin
        // saturate rather than wrap
        if (elapsed_ms != ELAPSED_MAX) elapsed_ms_next = elapsed_ms + 1'b1;
      end
      FUNC_START: begin
        start_position_next = position;
        brake               = 1'b1;
        if (at_home) begin
          active_next = 1'b0;
          ev          = EV_SKIPPED;
        end else begin
          active_next     = 1'b1;
          reversing_next  = 1'b1;
          switched_next   = 1'b0;
          elapsed_ms_next = '0;
          ev              = EV_STARTED;
        end
      end
      FUNC_ABORT: begin
        if (active) ev = EV_ABORTED;
        active_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      reversing      <= 1'b1;
      switched       <= 1'b0;
      start_position <= '0;
      elapsed_ms     <= '0;
    end else if (fire) begin
      active         <= active_next;
      reversing      <= reversing_next;
      switched       <= switched_next;
      start_position <= start_position_next;
      elapsed_ms     <= elapsed_ms_next;
    end
  end

  always_comb begin
    result.drive_a       = active_next && !reversing_next;
    result.drive_b       = active_next && reversing_next;
    result.brake_release = brake;
    result.rewinding     = active_next;
    result.event_res     = ev;
  end

endmodule

[sv/motor_rewind_homing_controller.sv]
// Top level of the rewind homing controller: request and result stages around the core.
//
// Requests arrive on in_valid/in_ready with func and position; each request
// yields exactly one result on out_valid/out_ready carrying the motor pin
// levels, the brake-release pulse, the rewinding flag and an event code.
// Configuration (home position, timeout, wrong-way margin) is written through
// cfg_we/cfg_index/cfg_data, one register per cycle, with no wait.
// A request is first captured in the request register; the core works between it
// and the result register, from which the result is offered.
// Throughput: one request per cycle while the receiver keeps up; the core's
// state is updated as a request moves from the request register into the result
// register, so back-to-back requests see the state left by the one before.
// When the receiver stalls, the result register holds and the request
// register takes one more request; in_ready drops only when both are full.
// Reset (rst, synchronous) empties both stages, restores the configuration
// defaults and returns the rewind state to idle with zero elapsed time.
module motor_rewind_homing_controller #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mrhc_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [mrhc_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         func,
  input  logic signed [POSITION_WIDTH-1:0]   position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               drive_a,
  output logic                               drive_b,
  output logic                               brake_release,
  output logic                               rewinding,
  output logic [2:0]                         event_res
);
  import mrhc_pkg::*;

  `include "motor_rewind_homing_controller_defines.svh"

  logic                             req_valid;
  func_t                            req_func;
  logic signed [POSITION_WIDTH-1:0] req_position;
  logic                             req_advance;
  result_t                          core_result;
  result_t                          res;

  assign req_advance = req_valid && (!out_valid || out_ready);
  assign in_ready    = !req_valid || req_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_func     <= func_t'(func);
      req_position <= position;
    end
  end

  mrhc_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fire     (req_advance),
    .func     (req_func),
    .position (req_position),
    .result   (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_advance) res <= core_result;
  end

  assign drive_a       = res.drive_a;
  assign drive_b       = res.drive_b;
  assign brake_release = res.brake_release;
  assign rewinding     = res.rewinding;
  assign event_res     = res.event_res;

  `MRHC_ASSERT_NOW(a_pins_exclusive, clk, rst, out_valid && (drive_a || drive_b),
    rewinding && (drive_a != drive_b))
  `MRHC_ASSERT_NOW(a_start_reverse, clk, rst, out_valid && (event_res == EV_STARTED),
    brake_release && drive_b && rewinding)
  `MRHC_ASSERT_NOW(a_stop_idle, clk, rst,
    out_valid && ((event_res == EV_SKIPPED) || (event_res == EV_COMPLETE) ||
    (event_res == EV_TIMEOUT) || (event_res == EV_ABORTED)), !rewinding)
  `MRHC_ASSERT_NEXT(a_req_held, clk, rst, req_valid && !req_advance,
    req_valid && $stable(req_func) && $stable(req_position))

endmodule

[sim/testbench.sv]
// Self-checking testbench for the motor rewind homing controller.
`timescale 1ns / 1ps

module testbench;
  import mrhc_pkg::*;

  localparam int    POS_W          = 32;
  localparam int    WATCHDOG_LIMIT = 1000;
  localparam int    LONG_HOLD      = 80;
  localparam longint POS_MAX       = 64'sd2147483647;
  localparam longint POS_MIN       = -64'sd2147483648;

  typedef struct {
    func_t                   fn;
    logic signed [POS_W-1:0] pos;
  } rewind_req_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]           cfg_index = CFG_HOME;
  logic [CFG_WIDTH-1:0]               cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [1:0]                         func = FUNC_UPDATE;
  logic signed [POS_W-1:0]            position = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic                               drive_a;
  logic                               drive_b;
  logic                               brake_release;
  logic                               rewinding;
  logic [2:0]                         event_res;

  // Requests waiting to be offered, and motor outputs predicted for accepted requests.
  rewind_req_t request_q[$];
  result_t     motor_out_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  // Controller copy: configuration and rewind state.
  logic [CFG_WIDTH-1:0]     cfg_home    = HOME_RESET;
  logic [CFG_WIDTH-1:0]     cfg_timeout = TIMEOUT_RESET;
  logic [CFG_WIDTH-1:0]     cfg_margin  = MARGIN_RESET;
  logic                     rw_active    = 1'b0;
  logic                     rw_reversing = 1'b1;
  logic                     rw_switched  = 1'b0;
  longint                   rw_start     = 0;
  logic [ELAPSED_WIDTH-1:0] rw_elapsed   = '0;

  motor_rewind_homing_controller #(
    .POSITION_WIDTH(POS_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .position     (position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_a      (drive_a),
    .drive_b      (drive_b),
    .brake_release(brake_release),
    .rewinding    (rewinding),
    .event_res    (event_res)
  );

  always #1 clk = ~clk;

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
    if (v > POS_MAX) return POS_MAX[POS_W-1:0];
    if (v < POS_MIN) return POS_MIN[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

  task automatic push_req(input func_t fn, input logic [POS_W-1:0] pos);
    rewind_req_t r;
    r.fn  = fn;
    r.pos = pos;
    request_q.push_back(r);
  endtask

  // Advance the rewind state by one request and queue the motor outputs it gives.
  task automatic advance_rewind(input rewind_req_t req);
    longint  p;
    longint  h;
    result_t r;
    p = req.pos;
    h = longint'(cfg_home);
    r.brake_release = 1'b0;
    r.event_res     = EV_NONE;
    case (req.fn)
      FUNC_UPDATE: begin
        if (rw_active) begin
          if (p <= h) begin
            rw_active       = 1'b0;
            r.brake_release = 1'b1;
            r.event_res     = EV_COMPLETE;
          end else if (rw_elapsed > cfg_timeout) begin
            rw_active       = 1'b0;
            r.brake_release = 1'b1;
            r.event_res     = EV_TIMEOUT;
          end else if (!rw_switched && p > rw_start &&
                       (p - rw_start) > longint'(cfg_margin)) begin
            rw_switched  = 1'b1;
            rw_reversing = 1'b0;
            r.event_res  = EV_SWITCHED;
          end
        end
      end
      FUNC_TICK: begin
        if (rw_elapsed < ELAPSED_MAX) rw_elapsed = rw_elapsed + 1'b1;
      end
      FUNC_START: begin
        rw_start        = p;
        r.brake_release = 1'b1;
        if (p <= h) begin
          rw_active   = 1'b0;
          r.event_res = EV_SKIPPED;
        end else begin
          rw_active    = 1'b1;
          rw_reversing = 1'b1;
          rw_switched  = 1'b0;
          rw_elapsed   = '0;
          r.event_res  = EV_STARTED;
        end
      end
      default: begin
        if (rw_active) r.event_res = EV_ABORTED;
        rw_active = 1'b0;
      end
    endcase
    r.drive_a   = rw_active && !rw_reversing;
    r.drive_b   = rw_active && rw_reversing;
    r.rewinding = rw_active;
    motor_out_q.push_back(r);
  endtask

  // Wait until every request has been offered and answered, then let the pipeline settle.
  task automatic drain_block(input int cycles);
    while (request_q.size() != 0 || motor_out_q.size() != 0 || in_valid) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_WIDTH-1:0] home,
                            input logic [CFG_WIDTH-1:0] timeout,
                            input logic [CFG_WIDTH-1:0] margin);
    drain_block(4);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HOME;
    cfg_data  <= home;
    cfg_home   = home;
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= timeout;
    cfg_timeout = timeout;
    @(posedge clk);
    cfg_index <= CFG_MARGIN;
    cfg_data  <= margin;
    cfg_margin = margin;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_WIDTH-1:0] pick_cfg(input int unsigned mid);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CFG_WIDTH'($urandom_range(0, mid));
    endcase
  endfunction

  // Sender: bursts of random length with random gaps; hold the request until taken.
  always @(posedge clk) begin : sender
    int   burst_left;
    int   gap_left;
    logic offer;
    logic hold;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready) begin
        advance_rewind(request_q[0]);
        void'(request_q.pop_front());
      end
      hold  = in_valid && !in_ready;
      offer = hold;
      if (!hold && request_q.size() != 0) begin
        if (burst_left > 0) begin
          offer = 1'b1;
          burst_left--;
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          burst_left = $urandom_range(1, 30) - 1;
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          offer      = 1'b1;
        end
      end
      in_valid <= offer;
      if (offer && !hold) begin
        func     <= request_q[0].fn;
        position <= request_q[0].pos;
      end
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off to back the block up.
  always @(posedge clk) begin : receiver
    int   run_left;
    int   stall_left;
    int   hold_left;
    int   taken;
    logic long_done;
    logic rdy;
    if (rst) begin
      out_ready <= 1'b0;
      run_left   = 0;
      stall_left = 0;
      hold_left  = 0;
      taken      = 0;
      long_done  = 1'b0;
    end else begin
      if (out_valid && out_ready) taken++;
      if (!long_done && taken >= 500) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        rdy = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rdy = 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        rdy = 1'b1;
        run_left--;
      end else begin
        run_left   = $urandom_range(1, 25);
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        rdy        = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin : check_outputs
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (motor_out_q.size() == 0) begin
        flag_mismatch("result with nothing outstanding, event_res", event_res, 0);
      end else begin
        want = motor_out_q.pop_front();
        if (drive_a !== want.drive_a) flag_mismatch("drive_a", drive_a, want.drive_a);
        if (drive_b !== want.drive_b) flag_mismatch("drive_b", drive_b, want.drive_b);
        if (brake_release !== want.brake_release)
          flag_mismatch("brake_release", brake_release, want.brake_release);
        if (rewinding !== want.rewinding)
          flag_mismatch("rewinding", rewinding, want.rewinding);
        if (event_res !== want.event_res)
          flag_mismatch("event_res", event_res, want.event_res);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int     queued;
    int     len;
    int     pick;
    longint base;
    longint near;

    // Default settings: idle requests, skip at home, margin edge, restart, abort, complete.
    push_req(FUNC_UPDATE, 32'sd0);
    push_req(FUNC_TICK, 32'hFFFF_FFFF);
    push_req(FUNC_ABORT, 32'sd0);
    push_req(FUNC_START, 32'sd25);
    push_req(FUNC_START, 32'h8000_0000);
    push_req(FUNC_START, 32'sd26);
    push_req(FUNC_UPDATE, 32'sd226);
    push_req(FUNC_UPDATE, 32'sd227);
    push_req(FUNC_UPDATE, 32'h7FFF_FFFF);
    push_req(FUNC_START, 32'h7FFF_FFFF);
    push_req(FUNC_UPDATE, 32'h7FFF_FFFF);
    push_req(FUNC_ABORT, 32'sd0);
    push_req(FUNC_START, 32'sd5000);
    push_req(FUNC_UPDATE, 32'sd25);
    push_req(FUNC_START, 32'sd5000);
    push_req(FUNC_UPDATE, 32'h8000_0000);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Highest home, zero timeout and margin: immediate switch, then timeout.
    write_regs('1, '0, '0);
    push_req(FUNC_START, 32'sd65535);
    push_req(FUNC_START, 32'sd65536);
    push_req(FUNC_UPDATE, 32'sd65537);
    push_req(FUNC_TICK, 32'sd0);
    push_req(FUNC_UPDATE, 32'sd70000);

    // Zero home, widest timeout and margin.
    write_regs('0, '1, '1);
    push_req(FUNC_START, 32'sd1);
    push_req(FUNC_UPDATE, 32'sd65536);
    push_req(FUNC_UPDATE, 32'sd65537);
    push_req(FUNC_UPDATE, 32'sd0);

    for (int ph = 0; ph < 8; ph++) begin
      write_regs(pick_cfg(300), pick_cfg(25), pick_cfg(400));
      queued = 0;
      while (queued < 130) begin
        if ($urandom_range(0, 4) == 0) base = longint'($signed($urandom));
        else base = longint'(cfg_home) + 1 + $urandom_range(0, 5000);
        push_req(FUNC_START, clamp_pos(base));
        len = $urandom_range(3, 20);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 40) begin
            push_req(FUNC_TICK, $urandom);
          end else if (pick < 80) begin
            case ($urandom_range(0, 4))
              0:       near = longint'(cfg_home) + $urandom_range(0, 2) - 1;
              1:       near = base + cfg_margin + $urandom_range(0, 2);
              2:       near = base + $urandom_range(0, cfg_margin);
              3:       near = base - $urandom_range(0, 1000);
              default: near = base + cfg_margin + $urandom_range(1, 100000);
            endcase
            push_req(FUNC_UPDATE, clamp_pos(near));
          end else if (pick < 86) begin
            push_req(FUNC_ABORT, $urandom);
          end else if (pick < 92) begin
            // restart mid-rewind, sometimes at or below home
            if ($urandom_range(0, 1) == 0) base = longint'(cfg_home) + $urandom_range(0, 2);
            else base = longint'($signed($urandom));
            push_req(FUNC_START, clamp_pos(base));
          end else begin
            push_req(FUNC_UPDATE, $urandom);
          end
        end
        queued += len + 1;
      end
    end

    drain_block(10);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
